// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion helpers for the frame receiver RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent in one cycle forces the consequent in the next one.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wsfr_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfr_pkg
// Types and constants shared by the WebSocket frame receiver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfr_pkg;

    // parser phases, one-hot
    typedef enum logic [5:0] {
        PH_HDR0  = 6'b000001,
        PH_HDR1  = 6'b000010,
        PH_EXT16 = 6'b000100,
        PH_MASK  = 6'b001000,
        PH_PAY   = 6'b010000,
        PH_EXT64 = 6'b100000
    } wsfr_phase_t;

    // result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_PONG  = 2'd2;
    localparam logic [1:0] KIND_FAIL  = 2'd3;

    // failure codes
    localparam logic [2:0] FAIL_NONE     = 3'd0;
    localparam logic [2:0] FAIL_RSV_BITS = 3'd1;
    localparam logic [2:0] FAIL_UNMASKED = 3'd2;
    localparam logic [2:0] FAIL_FRAG     = 3'd3;
    localparam logic [2:0] FAIL_RSV_OP   = 3'd4;
    localparam logic [2:0] FAIL_LEN16    = 3'd5;
    localparam logic [2:0] FAIL_LEN64    = 3'd6;
    localparam logic [2:0] FAIL_CTRL_LEN = 3'd7;

    // opcodes
    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'ha;
    localparam logic [3:0] OP_RSV_DATA_LO = 4'h3;
    localparam logic [3:0] OP_RSV_DATA_HI = 4'h7;
    localparam logic [3:0] OP_RSV_CTRL_LO = 4'hb;

    // length codes and limits
    localparam logic [6:0]  LEN7_EXT16    = 7'h7e;
    localparam logic [6:0]  LEN7_EXT64    = 7'h7f;
    localparam logic [6:0]  CTRL_MAX_LEN  = 7'd125;
    localparam logic [63:0] LEN16_MIN     = 64'h7e;
    localparam logic [63:0] LEN64_MAX_BAD = 64'hffff;
    localparam logic [3:0]  EXT16_BYTES   = 4'd2;
    localparam logic [3:0]  EXT64_BYTES   = 4'd8;
    localparam logic [3:0]  MASK_BYTES    = 4'd4;

    typedef struct packed {
        logic       vld;
        logic [1:0] kind;
        logic [7:0] data;
        logic [3:0] opcode;
        logic       frame_end;
        logic       message_end;
        logic       closed;
        logic [2:0] fail_code;
    } wsfr_result_t;

endpackage

`default_nettype wire

// ===== rtl/wsfr_core.sv =====
// ----------------------------------------------------------------------------
// wsfr_core
// Frame parser state and per-byte decode: header, extended length, mask key
// and payload unmasking. Produces at most one result per stepped byte.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module wsfr_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [7:0]            byte_in,
    output wsfr_pkg::wsfr_result_t     res
);
    import wsfr_pkg::*;

    wsfr_phase_t phase_reg, phase_next;
    logic [7:0]  fh_reg, fh_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [63:0] remain_reg, remain_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  midx_reg, midx_next;
    logic        frag_reg, frag_next;
    logic        closed_reg, closed_next;
    logic        failed_reg, failed_next;

    logic [3:0]  op;
    logic [6:0]  len7;
    logic [3:0]  cnt_dec;
    logic [63:0] remain_shift;
    logic [63:0] remain_dec;
    logic [7:0]  key_byte;
    logic        msg_done;
    logic        remain_last;

    assign op           = fh_reg[3:0];
    assign len7         = byte_in[6:0];
    assign cnt_dec      = cnt_reg - 4'd1;
    assign remain_shift = {remain_reg[55:0], byte_in};
    assign remain_dec   = remain_reg - 64'd1;
    assign remain_last  = (remain_dec == 64'd0);
    assign msg_done     = (op == OP_CLOSE) || ((op <= OP_BIN) && fh_reg[7]);

    always_comb
    begin
        case (midx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        fh_next     = fh_reg;
        cnt_next    = cnt_reg;
        remain_next = remain_reg;
        key_next    = key_reg;
        midx_next   = midx_reg;
        frag_next   = frag_reg;
        closed_next = closed_reg;
        failed_next = failed_reg;
        res         = '0;

        if (step && !failed_reg && !(closed_reg && phase_reg == PH_HDR0))
        begin
            case (phase_reg)
                PH_HDR0:
                begin
                    fh_next    = byte_in;
                    phase_next = PH_HDR1;
                end
                PH_HDR1:
                begin
                    res.kind = KIND_FAIL;
                    if (fh_reg[6:4] != 3'd0)
                        res.fail_code = FAIL_RSV_BITS;
                    else if (!byte_in[7])
                        res.fail_code = FAIL_UNMASKED;
                    else if ((op == OP_CONT && !frag_reg) ||
                             ((op == OP_TEXT || op == OP_BIN) && frag_reg))
                        res.fail_code = FAIL_FRAG;
                    else if ((op >= OP_RSV_DATA_LO && op <= OP_RSV_DATA_HI) ||
                             op >= OP_RSV_CTRL_LO)
                        res.fail_code = FAIL_RSV_OP;
                    else if (op >= OP_CLOSE && len7 > CTRL_MAX_LEN)
                        res.fail_code = FAIL_CTRL_LEN;
                    else
                        res.kind = KIND_DATA;

                    if (res.kind == KIND_FAIL)
                    begin
                        res.vld     = 1'b1;
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        if (op <= OP_BIN)
                            frag_next = !fh_reg[7];
                        if (op == OP_CLOSE)
                            closed_next = 1'b1;
                        key_next = '0;
                        if (len7 == LEN7_EXT16)
                        begin
                            remain_next = '0;
                            cnt_next    = EXT16_BYTES;
                            phase_next  = PH_EXT16;
                        end
                        else if (len7 == LEN7_EXT64)
                        begin
                            remain_next = '0;
                            cnt_next    = EXT64_BYTES;
                            phase_next  = PH_EXT64;
                        end
                        else
                        begin
                            remain_next = {57'd0, len7};
                            cnt_next    = MASK_BYTES;
                            phase_next  = PH_MASK;
                        end
                    end
                end
                PH_EXT16, PH_EXT64:
                begin
                    remain_next = remain_shift;
                    cnt_next    = cnt_dec;
                    if (cnt_dec == 4'd0)
                    begin
                        if (phase_reg == PH_EXT16 && remain_shift < LEN16_MIN)
                        begin
                            res.vld       = 1'b1;
                            res.kind      = KIND_FAIL;
                            res.fail_code = FAIL_LEN16;
                            failed_next   = 1'b1;
                        end
                        else if (phase_reg == PH_EXT64 &&
                                 (remain_shift[63] || remain_shift <= LEN64_MAX_BAD))
                        begin
                            res.vld       = 1'b1;
                            res.kind      = KIND_FAIL;
                            res.fail_code = FAIL_LEN64;
                            failed_next   = 1'b1;
                        end
                        else
                        begin
                            cnt_next   = MASK_BYTES;
                            phase_next = PH_MASK;
                        end
                    end
                end
                PH_MASK:
                begin
                    key_next = {key_reg[23:0], byte_in};
                    cnt_next = cnt_dec;
                    if (cnt_dec == 4'd0)
                    begin
                        midx_next = 2'd0;
                        if (remain_reg != 64'd0)
                            phase_next = PH_PAY;
                        else
                        begin
                            phase_next = PH_HDR0;
                            // empty frame marker, except for an empty pong
                            if (op != OP_PONG)
                            begin
                                res.vld         = 1'b1;
                                res.kind        = KIND_EMPTY;
                                res.frame_end   = 1'b1;
                                res.message_end = msg_done;
                            end
                        end
                    end
                end
                PH_PAY:
                begin
                    midx_next   = midx_reg + 2'd1;
                    remain_next = remain_dec;
                    if (remain_last)
                        phase_next = PH_HDR0;
                    if (op != OP_PONG)
                    begin
                        res.vld       = 1'b1;
                        res.data      = byte_in ^ key_byte;
                        res.frame_end = remain_last;
                        if (op == OP_PING)
                            res.kind = KIND_PONG;
                        else
                        begin
                            res.kind        = KIND_DATA;
                            res.message_end = remain_last && msg_done;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HDR0;
                end
            endcase
        end

        res.opcode = op;
        res.closed = closed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            fh_reg     <= '0;
            cnt_reg    <= '0;
            remain_reg <= '0;
            key_reg    <= '0;
            midx_reg   <= '0;
            frag_reg   <= 1'b0;
            closed_reg <= 1'b0;
            failed_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            fh_reg     <= fh_next;
            cnt_reg    <= cnt_next;
            remain_reg <= remain_next;
            key_reg    <= key_next;
            midx_reg   <= midx_next;
            frag_reg   <= frag_next;
            closed_reg <= closed_next;
            failed_reg <= failed_next;
        end
    end

    `ASSERT_NEXT(a_failed_sticky, clk, rst_n, failed_reg, failed_reg, "failed flag cleared")
    `ASSERT_ALWAYS(a_no_result_after_fail, clk, rst_n, !(failed_reg && res.vld),
        "result after failure")
    `ASSERT_NEXT(a_fail_sets_flag, clk, rst_n, res.vld && res.kind == KIND_FAIL, failed_reg,
        "failure result without failed flag")

endmodule

`default_nettype wire

// ===== rtl/websocket_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_receiver
// Server-side WebSocket deframer: one stream byte in, at most one result out.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry in_byte, one stream byte per transfer.
// Output channel: out_valid / out_stall carry one result per transfer: payload
//   byte, empty-frame marker, pong reply byte or a single failure report.
// A byte's result passes from the input register, loaded by the transfer,
//   through the decode into the result register, which drives out_valid.
// Throughput: one byte per cycle while out_stall does not hold a full result
//   register; header, length and mask bytes simply give no result. The rate is
//   set by the single decode stage between the input and result registers.
// Reset clears the parser to await a first header byte and empties both
//   registers. After a failure report or a completed close frame, further
//   bytes are taken and dropped.
// A stalled result holds; the input register still drains whenever the result
//   register is empty or being taken, so in_stall rises only when both are full
//   and out_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module websocket_frame_receiver (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      out_kind,
    output logic [7:0]      out_byte,
    output logic [3:0]      frame_opcode,
    output logic            frame_end,
    output logic            message_end,
    output logic            conn_closed,
    output logic [2:0]      fail_code
);
    import wsfr_pkg::*;

    logic         in_vld_reg, in_vld_next;
    logic [7:0]   in_byte_reg;
    logic         out_vld_reg, out_vld_next;
    wsfr_result_t out_reg;
    wsfr_result_t res;
    logic         adv;

    assign adv      = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !adv;

    wsfr_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (adv),
        .byte_in (in_byte_reg),
        .res     (res)
    );

    always_comb
    begin
        in_vld_next = in_stall ? in_vld_reg : in_valid;
        if (adv)
            out_vld_next = res.vld;
        else
            out_vld_next = out_vld_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_byte_reg <= in_byte;
        if (adv && res.vld)
            out_reg <= res;
    end

    assign out_valid    = out_vld_reg;
    assign out_kind     = out_reg.kind;
    assign out_byte     = out_reg.data;
    assign frame_opcode = out_reg.opcode;
    assign frame_end    = out_reg.frame_end;
    assign message_end  = out_reg.message_end;
    assign conn_closed  = out_reg.closed;
    assign fail_code    = out_reg.fail_code;

    `ASSERT_ALWAYS(a_stall_only_when_full, clk, rst_n,
        !in_stall || (in_vld_reg && out_vld_reg && out_stall), "input stalled with room")
    `ASSERT_NEXT(a_held_byte_stable, clk, rst_n, in_stall, in_vld_reg && $stable(in_byte_reg),
        "held input byte lost")
    `ASSERT_NEXT(a_taken_result_clears, clk, rst_n, out_vld_reg && !out_stall && !adv,
        !out_vld_reg, "result repeated after transfer")

endmodule

`default_nettype wire

// ===== sim/tb_websocket_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// tb_websocket_frame_receiver
// Self-checking bench for the WebSocket frame receiver. A short table of
// hand-built frames runs first. Random well-formed frames with random masks,
// payloads and fragmentation follow. The run ends with a close frame or one
// randomly chosen protocol violation followed by trailing bytes that the
// block must drop, or else with a data frame with a 64-bit length that is
// cut off partway into its payload. Every result is compared against a
// cycle-free deframer kept alongside the stream. Both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_websocket_frame_receiver;
    import wsfr_pkg::*;

    localparam int ITEMS_TARGET = 1550;
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int DRAIN_CYCLES = 16;

    typedef enum logic [1:0] {ROW_PRED, ROW_QUIET, ROW_FIXED} row_chk_t;
    typedef enum logic [1:0] {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

    typedef struct packed {
        logic [7:0] b;
        row_chk_t   chk;
        logic [1:0] kind;
        logic [7:0] data;
        logic [3:0] op;
        logic       fe;
        logic       me;
        logic       cl;
        logic [2:0] code;
    } dir_row_t;

    localparam int N_DIR = 27;
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        // empty text message, zero key
        '{8'h81, ROW_QUIET, KIND_DATA,  8'h00, OP_CONT, 1'b0, 1'b0, 1'b0, FAIL_NONE},
        '{8'h80, ROW_QUIET, KIND_DATA,  8'h00, OP_CONT, 1'b0, 1'b0, 1'b0, FAIL_NONE},
        '{8'h00, ROW_QUIET, KIND_DATA,  8'h00, OP_CONT, 1'b0, 1'b0, 1'b0, FAIL_NONE},
        '{8'h00, ROW_QUIET, KIND_DATA,  8'h00, OP_CONT, 1'b0, 1'b0, 1'b0, FAIL_NONE},
        '{8'h00, ROW_QUIET, KIND_DATA,  8'h00, OP_CONT, 1'b0, 1'b0, 1'b0, FAIL_NONE},
        '{8'h00, ROW_FIXED, KIND_EMPTY, 8'h00, OP_TEXT, 1'b1, 1'b1, 1'b0, FAIL_NONE},
        // two-byte binary fragment, all-ones key, no FIN
        '{8'h02, ROW_QUIET, KIND_DATA,  8'h00, OP_CONT, 1'b0, 1'b0, 1'b0, FAIL_NONE},
        '{8'h82, ROW_QUIET, KIND_DATA,  8'h00, OP_CONT, 1'b0, 1'b0, 1'b0, FAIL_NONE},
        '{8'hff, ROW_QUIET, KIND_DATA,  8'h00, OP_CONT, 1'b0, 1'b0, 1'b0, FAIL_NONE},
        '{8'hff, ROW_QUIET, KIND_DATA,  8'h00, OP_CONT, 1'b0, 1'b0, 1'b0, FAIL_NONE},
        '{8'hff, ROW_QUIET, KIND_DATA,  8'h00, OP_CONT, 1'b0, 1'b0, 1'b0, FAIL_NONE},
        '{8'hff, ROW_QUIET, KIND_DATA,  8'h00, OP_CONT, 1'b0, 1'b0, 1'b0, FAIL_NONE},
        '{8'h00, ROW_FIXED, KIND_DATA,  8'hff, OP_BIN,  1'b0, 1'b0, 1'b0, FAIL_NONE},
        '{8'hff, ROW_FIXED, KIND_DATA,  8'h00, OP_BIN,  1'b1, 1'b0, 1'b0, FAIL_NONE},
        // final continuation, one byte
        '{8'h80, ROW_QUIET, KIND_DATA,  8'h00, OP_CONT, 1'b0, 1'b0, 1'b0, FAIL_NONE},
        '{8'h81, ROW_QUIET, KIND_DATA,  8'h00, OP_CONT, 1'b0, 1'b0, 1'b0, FAIL_NONE},
        '{8'ha5, ROW_QUIET, KIND_DATA,  8'h00, OP_CONT, 1'b0, 1'b0, 1'b0, FAIL_NONE},
        '{8'h5a, ROW_QUIET, KIND_DATA,  8'h00, OP_CONT, 1'b0, 1'b0, 1'b0, FAIL_NONE},
        '{8'h3c, ROW_QUIET, KIND_DATA,  8'h00, OP_CONT, 1'b0, 1'b0, 1'b0, FAIL_NONE},
        '{8'hc3, ROW_QUIET, KIND_DATA,  8'h00, OP_CONT, 1'b0, 1'b0, 1'b0, FAIL_NONE},
        '{8'h5a, ROW_PRED,  KIND_DATA,  8'h00, OP_CONT, 1'b0, 1'b0, 1'b0, FAIL_NONE},
        // empty pong gives nothing
        '{8'h8a, ROW_QUIET, KIND_DATA,  8'h00, OP_CONT, 1'b0, 1'b0, 1'b0, FAIL_NONE},
        '{8'h80, ROW_QUIET, KIND_DATA,  8'h00, OP_CONT, 1'b0, 1'b0, 1'b0, FAIL_NONE},
        '{8'h12, ROW_QUIET, KIND_DATA,  8'h00, OP_CONT, 1'b0, 1'b0, 1'b0, FAIL_NONE},
        '{8'h34, ROW_QUIET, KIND_DATA,  8'h00, OP_CONT, 1'b0, 1'b0, 1'b0, FAIL_NONE},
        '{8'h56, ROW_QUIET, KIND_DATA,  8'h00, OP_CONT, 1'b0, 1'b0, 1'b0, FAIL_NONE},
        '{8'h78, ROW_QUIET, KIND_DATA,  8'h00, OP_CONT, 1'b0, 1'b0, 1'b0, FAIL_NONE}
    };

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] in_byte   = 8'h00;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [3:0] frame_opcode;
    logic       frame_end;
    logic       message_end;
    logic       conn_closed;
    logic [2:0] fail_code;

    websocket_frame_receiver u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_kind     (out_kind),
        .out_byte     (out_byte),
        .frame_opcode (frame_opcode),
        .frame_end    (frame_end),
        .message_end  (message_end),
        .conn_closed  (conn_closed),
        .fail_code    (fail_code)
    );

    always #1 clk = ~clk;

    // deframer state
    wsfr_phase_t ws_phase;
    logic [7:0]  ws_hdr0;
    logic [3:0]  ws_cnt;
    logic [63:0] ws_left;
    logic [31:0] ws_key;
    logic [1:0]  ws_key_idx;
    logic        ws_frag_open;
    logic        ws_closed;
    logic        ws_failed;

    wsfr_result_t deframed_q [$];
    wsfr_result_t due;
    int          err_count   = 0;
    int unsigned cycle_count = 0;
    int unsigned n_sent      = 0;
    int unsigned burst_left  = 0;

    stall_mode_t stall_mode = STALL_NONE;
    int unsigned stall_tick = 0;

    task automatic ws_reset_state();
        ws_phase     = PH_HDR0;
        ws_hdr0      = 8'h00;
        ws_cnt       = 4'd0;
        ws_left      = 64'd0;
        ws_key       = 32'd0;
        ws_key_idx   = 2'd0;
        ws_frag_open = 1'b0;
        ws_closed    = 1'b0;
        ws_failed    = 1'b0;
    endtask

    function automatic logic msg_done();
        return (ws_hdr0[3:0] == OP_CLOSE) || (ws_hdr0[3:0] <= OP_BIN && ws_hdr0[7]);
    endfunction

    function automatic wsfr_result_t result_of(logic [1:0] kind, logic [7:0] data,
                                               logic fe, logic me, logic [2:0] code);
        wsfr_result_t r;
        r.vld         = 1'b1;
        r.kind        = kind;
        r.data        = data;
        r.opcode      = ws_hdr0[3:0];
        r.frame_end   = fe;
        r.message_end = me;
        r.closed      = ws_closed;
        r.fail_code   = code;
        return r;
    endfunction

    task automatic deframe_byte(input logic [7:0] b, output bit has, output wsfr_result_t r);
        logic [3:0] op;
        logic [6:0] len7;
        logic [2:0] fcode;
        logic [7:0] v;
        logic       done;
        op    = ws_hdr0[3:0];
        len7  = b[6:0];
        fcode = FAIL_NONE;
        has   = 1'b0;
        r     = '0;
        if (ws_failed || (ws_closed && ws_phase == PH_HDR0))
            return;
        case (ws_phase)
            PH_HDR0:
            begin
                ws_hdr0  = b;
                ws_phase = PH_HDR1;
            end
            PH_HDR1:
            begin
                if (ws_hdr0[6:4] != 3'b000)
                    fcode = FAIL_RSV_BITS;
                else if (!b[7])
                    fcode = FAIL_UNMASKED;
                else if ((op == OP_CONT && !ws_frag_open)
                         || ((op == OP_TEXT || op == OP_BIN) && ws_frag_open))
                    fcode = FAIL_FRAG;
                else if ((op >= OP_RSV_DATA_LO && op <= OP_RSV_DATA_HI) || op >= OP_RSV_CTRL_LO)
                    fcode = FAIL_RSV_OP;
                else if (op >= OP_CLOSE && len7 > CTRL_MAX_LEN)
                    fcode = FAIL_CTRL_LEN;
                else
                begin
                    if (op <= OP_BIN)
                        ws_frag_open = !ws_hdr0[7];
                    if (op == OP_CLOSE)
                        ws_closed = 1'b1;
                    ws_left = 64'd0;
                    ws_key  = 32'd0;
                    if (len7 == LEN7_EXT16)
                    begin
                        ws_cnt   = EXT16_BYTES;
                        ws_phase = PH_EXT16;
                    end
                    else if (len7 == LEN7_EXT64)
                    begin
                        ws_cnt   = EXT64_BYTES;
                        ws_phase = PH_EXT64;
                    end
                    else
                    begin
                        ws_left  = {57'd0, len7};
                        ws_cnt   = MASK_BYTES;
                        ws_phase = PH_MASK;
                    end
                end
            end
            PH_EXT16, PH_EXT64:
            begin
                ws_left = {ws_left[55:0], b};
                ws_cnt  = ws_cnt - 4'd1;
                if (ws_cnt == 4'd0)
                begin
                    if (ws_phase == PH_EXT16 && ws_left < LEN16_MIN)
                        fcode = FAIL_LEN16;
                    else if (ws_phase == PH_EXT64 && (ws_left[63] || ws_left <= LEN64_MAX_BAD))
                        fcode = FAIL_LEN64;
                    else
                    begin
                        ws_cnt   = MASK_BYTES;
                        ws_phase = PH_MASK;
                    end
                end
            end
            PH_MASK:
            begin
                ws_key = {ws_key[23:0], b};
                ws_cnt = ws_cnt - 4'd1;
                if (ws_cnt == 4'd0)
                begin
                    ws_key_idx = 2'd0;
                    if (ws_left != 64'd0)
                        ws_phase = PH_PAY;
                    else
                    begin
                        ws_phase = PH_HDR0;
                        if (op != OP_PONG)
                        begin
                            has = 1'b1;
                            r   = result_of(KIND_EMPTY, 8'h00, 1'b1, msg_done(), FAIL_NONE);
                        end
                    end
                end
            end
            PH_PAY:
            begin
                // key byte 0 is the first mask byte received, i.e. the top byte
                v          = b ^ ws_key[8 * (3 - ws_key_idx) +: 8];
                ws_key_idx = ws_key_idx + 2'd1;
                ws_left    = ws_left - 64'd1;
                done       = (ws_left == 64'd0);
                if (done)
                    ws_phase = PH_HDR0;
                if (op == OP_PING)
                begin
                    has = 1'b1;
                    r   = result_of(KIND_PONG, v, done, 1'b0, FAIL_NONE);
                end
                else if (op != OP_PONG)
                begin
                    has = 1'b1;
                    r   = result_of(KIND_DATA, v, done, done && msg_done(), FAIL_NONE);
                end
            end
            default:
                ws_phase = PH_HDR0;
        endcase
        if (fcode != FAIL_NONE)
        begin
            ws_failed = 1'b1;
            has       = 1'b1;
            r         = result_of(KIND_FAIL, 8'h00, 1'b0, 1'b0, fcode);
        end
    endtask

    // one transfer on the input side, with burst/gap pacing in front of it
    task automatic push_byte(input logic [7:0] b, output bit has, output wsfr_result_t r);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                in_byte  <= 8'($urandom);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        deframe_byte(b, has, r);
    endtask

    task automatic send_byte(input logic [7:0] b);
        bit           has;
        wsfr_result_t r;
        push_byte(b, has, r);
        if (has)
            deframed_q.push_back(r);
        n_sent++;
    endtask

    task automatic send_frame(input logic [7:0] h0, input logic mask_bit, input logic [6:0] len7,
                              input logic [63:0] ext_len, input bit with_body);
        logic [63:0]     body_len;
        longint unsigned k;
        int              i;
        send_byte(h0);
        send_byte({mask_bit, len7});
        if (len7 == LEN7_EXT16)
        begin
            send_byte(ext_len[15:8]);
            send_byte(ext_len[7:0]);
            body_len = {48'd0, ext_len[15:0]};
        end
        else if (len7 == LEN7_EXT64)
        begin
            for (i = 7; i >= 0; i--)
                send_byte(ext_len[8 * i +: 8]);
            body_len = ext_len;
        end
        else
            body_len = {57'd0, len7};
        if (with_body)
        begin
            repeat (4) send_byte(8'($urandom));
            for (k = 0; k < body_len; k++)
                send_byte(8'($urandom));
        end
    endtask

    function automatic logic [3:0] next_data_op();
        if (ws_frag_open)
            return OP_CONT;
        return ($urandom_range(0, 1) != 0) ? OP_TEXT : OP_BIN;
    endfunction

    task automatic send_good_frame();
        logic [3:0]  op;
        logic        fin;
        logic [6:0]  len7;
        logic [63:0] ext;
        int unsigned sel;
        int unsigned lsel;
        bit          ctrl;
        sel  = $urandom_range(0, 9);
        lsel = $urandom_range(0, 19);
        ctrl = sel >= 7;
        fin  = 1'($urandom);
        ext  = 64'd0;
        op   = ctrl ? ((sel == 9) ? OP_PONG : OP_PING) : next_data_op();
        if (lsel < 2)
            len7 = 7'd0;
        else if (lsel < 16)
            len7 = 7'($urandom_range(1, 12));
        else if (lsel < 18 || ctrl)
            len7 = ($urandom_range(0, 3) == 0) ? CTRL_MAX_LEN : 7'($urandom_range(13, 125));
        else
        begin
            len7 = LEN7_EXT16;
            ext  = ($urandom_range(0, 3) == 0) ? LEN16_MIN : 64'($urandom_range(127, 400));
        end
        send_frame({fin, 3'b000, op}, 1'b1, len7, ext, 1'b1);
    endtask

    // data frame with a 64-bit length; the stream stops partway into its payload
    task automatic send_big_tail();
        logic [63:0] ext;
        ext = ($urandom_range(0, 1) != 0) ? 64'h1_0000 + 64'($urandom_range(0, 3))
                                          : ({1'b0, 31'($urandom), 32'($urandom)}
                                             | 64'h1_0000);
        send_frame({1'($urandom), 3'b000, next_data_op()}, 1'b1, LEN7_EXT64, ext, 1'b0);
        repeat (4) send_byte(8'($urandom));
        repeat ($urandom_range(16, 64)) send_byte(8'($urandom));
    endtask

    // close frame or one protocol violation, then bytes the block must drop
    task automatic send_ending();
        logic [2:0]  term;
        logic [3:0]  op;
        logic [63:0] ext;
        term = 3'($urandom_range(0, 7));
        case (term)
            FAIL_NONE:
                send_frame({1'($urandom), 3'b000, OP_CLOSE}, 1'b1, 7'($urandom_range(0, 10)),
                           64'd0, 1'b1);
            FAIL_RSV_BITS:
                send_frame({1'($urandom), 3'($urandom_range(1, 7)), 4'($urandom)},
                           1'($urandom), 7'($urandom), 64'd0, 1'b0);
            FAIL_UNMASKED:
                send_frame({1'($urandom), 3'b000, next_data_op()}, 1'b0, 7'($urandom),
                           64'd0, 1'b0);
            FAIL_FRAG:
            begin
                op = ws_frag_open ? (($urandom_range(0, 1) != 0) ? OP_TEXT : OP_BIN) : OP_CONT;
                send_frame({1'($urandom), 3'b000, op}, 1'b1, 7'($urandom), 64'd0, 1'b0);
            end
            FAIL_RSV_OP:
            begin
                op = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(3, 7))
                                                 : 4'($urandom_range(11, 15));
                send_frame({1'($urandom), 3'b000, op}, 1'b1, 7'($urandom), 64'd0, 1'b0);
            end
            FAIL_LEN16:
                send_frame({1'($urandom), 3'b000, next_data_op()}, 1'b1, LEN7_EXT16,
                           64'($urandom_range(0, 125)), 1'b0);
            FAIL_LEN64:
            begin
                ext = ($urandom_range(0, 1) != 0) ? {1'b1, 31'($urandom), 32'($urandom)}
                                                  : 64'($urandom_range(0, 65535));
                send_frame({1'($urandom), 3'b000, next_data_op()}, 1'b1, LEN7_EXT64, ext, 1'b0);
            end
            default:
            begin
                op = 4'($urandom_range(8, 10));
                send_frame({1'($urandom), 3'b000, op}, 1'b1,
                           ($urandom_range(0, 1) != 0) ? LEN7_EXT16 : LEN7_EXT64, 64'd0, 1'b0);
            end
        endcase
        repeat ($urandom_range(8, 24)) send_byte(8'($urandom));
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            if (deframed_q.size() == 0)
            begin
                $display("%0t: result expected none actual kind %0d byte %02h code %0d",
                         $time, out_kind, out_byte, fail_code);
                err_count++;
            end
            else
            begin
                due = deframed_q.pop_front();
                check_field("out_kind", 32'(due.kind), 32'(out_kind));
                check_field("out_byte", 32'(due.data), 32'(out_byte));
                check_field("frame_opcode", 32'(due.opcode), 32'(frame_opcode));
                check_field("frame_end", 32'(due.frame_end), 32'(frame_end));
                check_field("message_end", 32'(due.message_end), 32'(message_end));
                check_field("conn_closed", 32'(due.closed), 32'(conn_closed));
                check_field("fail_code", 32'(due.fail_code), 32'(fail_code));
            end
        end
    end

    always @(negedge clk)
    begin
        stall_tick++;
        if (stall_tick % 512 == 0)
            stall_mode = stall_mode_t'($urandom_range(0, 3));
        case (stall_mode)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_SPARSE:   out_stall <= ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: out_stall <= (stall_tick % 16 < 5);
            default:        out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("websocket_frame_receiver: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        bit           has;
        wsfr_result_t r;
        wsfr_result_t fixed;
        ws_reset_state();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++)
        begin
            push_byte(DIR_ROWS[i].b, has, r);
            case (DIR_ROWS[i].chk)
                ROW_FIXED:
                begin
                    fixed.vld         = 1'b1;
                    fixed.kind        = DIR_ROWS[i].kind;
                    fixed.data        = DIR_ROWS[i].data;
                    fixed.opcode      = DIR_ROWS[i].op;
                    fixed.frame_end   = DIR_ROWS[i].fe;
                    fixed.message_end = DIR_ROWS[i].me;
                    fixed.closed      = DIR_ROWS[i].cl;
                    fixed.fail_code   = DIR_ROWS[i].code;
                    deframed_q.push_back(fixed);
                end
                ROW_PRED:
                    if (has)
                        deframed_q.push_back(r);
                default:
                    ;
            endcase
        end

        while (n_sent < ITEMS_TARGET)
            send_good_frame();
        if ($urandom_range(0, 2) == 0)
            send_big_tail();
        else
            send_ending();

        @(negedge clk);
        in_valid <= 1'b0;
        while (deframed_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("websocket_frame_receiver: match");
        else
            $display("websocket_frame_receiver: mismatch");
        $finish;
    end

endmodule

// ===== websocket_frame_receiver.f =====
+incdir+rtl
rtl/wsfr_pkg.sv
rtl/wsfr_core.sv
rtl/websocket_frame_receiver.sv
sim/tb_websocket_frame_receiver.sv
